[sv/jacobi_3d_six_neighbour_stencil_macros.svh]
// assertion macros for the 3d jacobi stencil block
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef JACOBI_3D_SIX_NEIGHBOUR_STENCIL_MACROS_SVH
`define JACOBI_3D_SIX_NEIGHBOUR_STENCIL_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define J3D_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define J3D_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define J3D_ASSERT_IMP(name, ante, cons, msg)
`define J3D_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

[sv/j3d_pkg.sv]
// shared types and constants for the 3d jacobi stencil block
// no dependencies
package j3d_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned CFG_W        = 6;
  localparam int unsigned MIN_EDGE     = 3;
  localparam int unsigned MAX_EDGE_DEF = 32;
  localparam int unsigned GRID_RESET   = 32;

  // floor(2^32 / 3), used for the divide by three after halving
  localparam int unsigned RECIP_W = 31;
  localparam logic [RECIP_W-1:0] RECIP3 = 31'h5555_5555;

  // the six face neighbours of the output cell
  typedef struct packed {
    logic signed [DATA_W-1:0] cur;       // plane + 1 (arriving word)
    logic signed [DATA_W-1:0] below;     // plane - 1
    logic signed [DATA_W-1:0] row_next;
    logic signed [DATA_W-1:0] row_prev;
    logic signed [DATA_W-1:0] col_next;
    logic signed [DATA_W-1:0] col_prev;
  } win_t;

  // per-word bookkeeping carried down the pipeline
  typedef struct packed {
    logic [IDX_W-1:0]         plane;     // plane of the arriving word
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         column;
    logic signed [DATA_W-1:0] cur;
    logic signed [DATA_W-1:0] center;
    logic                     boundary;
    logic                     first;     // produces the cell one plane back
    logic                     last_plane;
    logic                     done;
  } item_t;

endpackage

[sv/jacobi_3d_six_neighbour_stencil.sv]
// Streaming 3d six-point Jacobi sweep. Cells of an N x N x N cube (N from the grid_size
// register, 3..MAX_EDGE) enter in raster order, one word per cycle while the output is not
// stalled. Each word of plane p >= 1 produces the cell one plane back at the same row and
// column: interior cells get the average of their six face neighbours, rounded to nearest
// with ties away from zero, and boundary cells pass through. Words of the last plane also
// pass straight out as a second result, so during that plane the block takes no new word
// while a second result is pending; elsewhere it takes one every cycle when not stalled. An
// accepted word passes through the delay chain read and window registers (loaded by the
// accepting edge), five datapath stages and the output register. Neighbours come from a chain
// of four delay memories (two of N*N-N-1 and two of N-2 words) plus three registers, each
// memory doing one write and one read per word. Writing grid_size restarts the cube at the
// origin; no clearing pass is needed after reset.
`include "jacobi_3d_six_neighbour_stencil_macros.svh"
module jacobi_3d_six_neighbour_stencil #(
  parameter int unsigned MAX_EDGE = j3d_pkg::MAX_EDGE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [j3d_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [j3d_pkg::DATA_W-1:0] cell_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [j3d_pkg::IDX_W-1:0]         plane_index_o,
  output logic [j3d_pkg::IDX_W-1:0]         row_index_o,
  output logic [j3d_pkg::IDX_W-1:0]         column_index_o,
  output logic signed [j3d_pkg::DATA_W-1:0] new_value_o,
  output logic                              run_last_o,
  output logic                              grid_done_o
);

  logic                              en;
  logic                              win_valid, avg_valid;
  j3d_pkg::win_t                     win;
  j3d_pkg::item_t                    win_item, avg_item;
  logic signed [j3d_pkg::DATA_W-1:0] avg_value;

  // whole pipeline moves together whenever the output register can take a word
  assign in_ready_o = en;

  j3d_window #(.MAX_EDGE(MAX_EDGE)) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .en_i         (en),
    .in_valid_i   (in_valid_i),
    .cell_value_i (cell_value_i),
    .valid_o      (win_valid),
    .win_o        (win),
    .item_o       (win_item)
  );

  j3d_avg u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (win_valid),
    .win_i   (win),
    .item_i  (win_item),
    .valid_o (avg_valid),
    .value_o (avg_value),
    .item_o  (avg_item)
  );

  j3d_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (avg_valid),
    .value_i        (avg_value),
    .item_i         (avg_item),
    .ready_o        (en),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .plane_index_o  (plane_index_o),
    .row_index_o    (row_index_o),
    .column_index_o (column_index_o),
    .new_value_o    (new_value_o),
    .run_last_o     (run_last_o),
    .grid_done_o    (grid_done_o)
  );

  logic out_fire;
  assign out_fire = out_valid_o && out_ready_i;

  `J3D_ASSERT_NXT(a_second_follows, out_fire && !run_last_o, out_valid_o && run_last_o, "pass-through word missing")
  `J3D_ASSERT_NXT(a_second_same_col, out_fire && !run_last_o, column_index_o == $past(column_index_o), "column moved")
  `J3D_ASSERT_IMP(a_done_is_last, out_valid_o && grid_done_o, run_last_o, "grid_done without run_last")
  `J3D_ASSERT_IMP(a_stall_blocks_input, out_valid_o && !out_ready_i, !in_ready_o, "input taken during stall")

endmodule

[sv/j3d_delay.sv]
// circular delay line on one memory, one write and one registered read per shift
// depends on j3d_pkg
module j3d_delay #(
  parameter  int unsigned DEPTH = 2,
  localparam int unsigned LW    = $clog2(DEPTH + 1),
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 clear_i,
  input  logic                                 shift_i,
  input  logic [LW-1:0]                        len_i,
  input  logic signed [j3d_pkg::DATA_W-1:0]    data_i,
  output logic signed [j3d_pkg::DATA_W-1:0]    data_o
);

  logic signed [j3d_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic signed [j3d_pkg::DATA_W-1:0] rd_q;
  logic [PW-1:0] ptr_q, ptr_d;

  always_comb begin
    ptr_d = ptr_q;
    if (clear_i) begin
      ptr_d = '0;
    end else if (shift_i) begin
      if (LW'(ptr_q) == len_i - LW'(1)) begin
        ptr_d = '0;
      end else begin
        ptr_d = ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else begin
      ptr_q <= ptr_d;
    end
  end

  // read-first: the word leaving is the one written len shifts ago
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      mem_q[ptr_q] <= data_i;
      rd_q         <= mem_q[ptr_q];
    end
  end

  assign data_o = rd_q;

endmodule

[sv/j3d_window.sv]
// raster counters, size register and the delay chain that lines up the six neighbours
// depends on j3d_pkg and j3d_delay
module j3d_window #(
  parameter int unsigned MAX_EDGE = j3d_pkg::MAX_EDGE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [j3d_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              en_i,
  input  logic                              in_valid_i,
  input  logic signed [j3d_pkg::DATA_W-1:0] cell_value_i,
  output logic                              valid_o,
  output j3d_pkg::win_t                     win_o,
  output j3d_pkg::item_t                    item_o
);

  localparam int unsigned EW          = $clog2(MAX_EDGE + 1);
  localparam int unsigned CW          = $clog2(MAX_EDGE);
  localparam int unsigned AW          = 2 * EW;
  localparam int unsigned BIG_DEPTH   = MAX_EDGE * (MAX_EDGE - 1) - 1;
  localparam int unsigned SMALL_DEPTH = MAX_EDGE - 2;
  localparam int unsigned BLW         = $clog2(BIG_DEPTH + 1);
  localparam int unsigned SLW         = $clog2(SMALL_DEPTH + 1);
  localparam int unsigned RST_EDGE    =
      (j3d_pkg::GRID_RESET > MAX_EDGE) ? MAX_EDGE : j3d_pkg::GRID_RESET;
  localparam int unsigned RST_BIG     = RST_EDGE * (RST_EDGE - 1) - 1;
  localparam int unsigned RST_SMALL   = RST_EDGE - 2;

  logic accept;
  assign accept = en_i && in_valid_i;

  // size register and the delay lengths it sets
  logic [EW-1:0]  edge_q, edge_d, last_idx;
  logic [AW-1:0]  area_d;
  logic [BLW-1:0] big_q, big_d;
  logic [SLW-1:0] small_q, small_d;

  always_comb begin
    if (cfg_wdata_i < j3d_pkg::CFG_W'(j3d_pkg::MIN_EDGE)) begin
      edge_d = EW'(j3d_pkg::MIN_EDGE);
    end else if (32'(cfg_wdata_i) > MAX_EDGE) begin
      edge_d = EW'(MAX_EDGE);
    end else begin
      edge_d = EW'(cfg_wdata_i);
    end
    area_d  = AW'(edge_d) * AW'(edge_d - EW'(1));
    big_d   = BLW'(area_d - AW'(1));
    small_d = SLW'(edge_d - EW'(2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q  <= EW'(RST_EDGE);
      big_q   <= BLW'(RST_BIG);
      small_q <= SLW'(RST_SMALL);
    end else if (cfg_we_i) begin
      edge_q  <= edge_d;
      big_q   <= big_d;
      small_q <= small_d;
    end
  end

  assign last_idx = edge_q - EW'(1);

  // position of the next word
  logic [CW-1:0] plane_cnt_q, row_cnt_q, col_cnt_q;
  logic [CW-1:0] plane_cnt_d, row_cnt_d, col_cnt_d;
  logic          plane_end, row_end, col_end;

  assign plane_end = (EW'(plane_cnt_q) == last_idx);
  assign row_end   = (EW'(row_cnt_q) == last_idx);
  assign col_end   = (EW'(col_cnt_q) == last_idx);

  always_comb begin
    plane_cnt_d = plane_cnt_q;
    row_cnt_d   = row_cnt_q;
    col_cnt_d   = col_cnt_q;
    if (cfg_we_i) begin
      plane_cnt_d = '0;
      row_cnt_d   = '0;
      col_cnt_d   = '0;
    end else if (accept) begin
      if (!col_end) begin
        col_cnt_d = col_cnt_q + CW'(1);
      end else begin
        col_cnt_d = '0;
        if (!row_end) begin
          row_cnt_d = row_cnt_q + CW'(1);
        end else begin
          row_cnt_d   = '0;
          plane_cnt_d = plane_end ? '0 : plane_cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_cnt_q <= '0;
      row_cnt_q   <= '0;
      col_cnt_q   <= '0;
    end else begin
      plane_cnt_q <= plane_cnt_d;
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
    end
  end

  logic valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_valid_i;
    end
  end

  // coordinates and flags of the word just taken
  logic [j3d_pkg::IDX_W-1:0] plane_q, row_q, col_q;
  logic boundary_q, first_q, last_plane_q, done_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      plane_q      <= j3d_pkg::IDX_W'(plane_cnt_q);
      row_q        <= j3d_pkg::IDX_W'(row_cnt_q);
      col_q        <= j3d_pkg::IDX_W'(col_cnt_q);
      first_q      <= (plane_cnt_q != '0);
      last_plane_q <= plane_end;
      done_q       <= plane_end && row_end && col_end;
      // output cell sits on plane zero when the arriving word is on plane one
      boundary_q   <= (plane_cnt_q == CW'(1)) || (row_cnt_q == '0) || row_end ||
                      (col_cnt_q == '0) || col_end;
    end
  end

  // delay chain: cur, +n^2-n, +n^2-1, +n^2, +n^2+1, +n^2+n, +2n^2 words back
  logic signed [j3d_pkg::DATA_W-1:0] cur_q, ctr_q, col_prev_q;
  logic signed [j3d_pkg::DATA_W-1:0] row_next, col_next, row_prev, below;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q      <= cell_value_i;
      ctr_q      <= col_next;
      col_prev_q <= ctr_q;
    end
  end

  j3d_delay #(.DEPTH(BIG_DEPTH)) u_row_ahead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we_i),
    .shift_i (accept),
    .len_i   (big_q),
    .data_i  (cur_q),
    .data_o  (row_next)
  );

  j3d_delay #(.DEPTH(SMALL_DEPTH)) u_col_ahead (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we_i),
    .shift_i (accept),
    .len_i   (small_q),
    .data_i  (row_next),
    .data_o  (col_next)
  );

  j3d_delay #(.DEPTH(SMALL_DEPTH)) u_row_behind (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we_i),
    .shift_i (accept),
    .len_i   (small_q),
    .data_i  (col_prev_q),
    .data_o  (row_prev)
  );

  j3d_delay #(.DEPTH(BIG_DEPTH)) u_plane_behind (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we_i),
    .shift_i (accept),
    .len_i   (big_q),
    .data_i  (row_prev),
    .data_o  (below)
  );

  assign valid_o = valid_q;

  always_comb begin
    win_o.cur      = cur_q;
    win_o.below    = below;
    win_o.row_next = row_next;
    win_o.row_prev = row_prev;
    win_o.col_next = col_next;
    win_o.col_prev = col_prev_q;

    item_o.plane      = plane_q;
    item_o.row        = row_q;
    item_o.column     = col_q;
    item_o.cur        = cur_q;
    item_o.center     = ctr_q;
    item_o.boundary   = boundary_q;
    item_o.first      = first_q;
    item_o.last_plane = last_plane_q;
    item_o.done       = done_q;
  end

endmodule

[sv/j3d_avg.sv]
// five-stage datapath: neighbour sum, magnitude, divide by six with rounding
// depends on j3d_pkg
module j3d_avg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  j3d_pkg::win_t                     win_i,
  input  j3d_pkg::item_t                    item_i,
  output logic                              valid_o,
  output logic signed [j3d_pkg::DATA_W-1:0] value_o,
  output j3d_pkg::item_t                    item_o
);

  localparam int unsigned DW  = j3d_pkg::DATA_W;
  localparam int unsigned PSW = DW + 2;               // sum of three words
  localparam int unsigned SW  = DW + 3;               // sum of six words
  localparam int unsigned XW  = DW + 1;               // (|sum| + 3) / 2
  localparam int unsigned MW  = XW + j3d_pkg::RECIP_W;

  logic s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, s6_valid_q;
  j3d_pkg::item_t s2_item_q, s3_item_q, s4_item_q, s5_item_q, s6_item_q;

  logic signed [PSW-1:0] sum_a_q, sum_b_q;
  logic signed [SW-1:0]  total_q;
  logic [SW-1:0]         mag;
  logic [XW-1:0]         half_q;
  logic                  neg4_q, neg5_q;
  logic [MW-1:0]         prod;
  logic [DW-1:0]         q0_q;
  logic [2:0]            xl_q, rem3;
  logic                  bump;
  logic [DW-1:0]         avg;
  logic signed [DW-1:0]  value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= valid_i;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  // |s| + 3 as one add: negative sums use ~s + 4
  always_comb begin
    if (total_q[SW-1]) begin
      mag = ~total_q + SW'(4);
    end else begin
      mag = total_q + SW'(3);
    end
  end

  assign prod = MW'(half_q) * MW'(j3d_pkg::RECIP3);

  // q0 is floor(x/3) or one below; the remainder fits in three bits
  always_comb begin
    rem3 = xl_q - (q0_q[2:0] + {q0_q[1:0], 1'b0});
    bump = (rem3 >= 3'd3);
    if (neg5_q) begin
      avg = ~q0_q + DW'(!bump);
    end else begin
      avg = q0_q + DW'(bump);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_a_q   <= PSW'(win_i.cur) + PSW'(win_i.below) + PSW'(win_i.row_next);
      sum_b_q   <= PSW'(win_i.row_prev) + PSW'(win_i.col_next) + PSW'(win_i.col_prev);
      s2_item_q <= item_i;

      total_q   <= SW'(sum_a_q) + SW'(sum_b_q);
      s3_item_q <= s2_item_q;

      half_q    <= mag[XW:1];
      neg4_q    <= total_q[SW-1];
      s4_item_q <= s3_item_q;

      q0_q      <= prod[DW +: DW];
      xl_q      <= half_q[2:0];
      neg5_q    <= neg4_q;
      s5_item_q <= s4_item_q;

      value_q   <= s5_item_q.boundary ? s5_item_q.center : $signed(avg);
      s6_item_q <= s5_item_q;
    end
  end

  assign valid_o = s6_valid_q;
  assign value_o = value_q;
  assign item_o  = s6_item_q;

endmodule

[sv/j3d_emit.sv]
// output register: turns a word into zero, one or two result words
// depends on j3d_pkg
module j3d_emit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [j3d_pkg::DATA_W-1:0] value_i,
  input  j3d_pkg::item_t                    item_i,
  output logic                              ready_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [j3d_pkg::IDX_W-1:0]         plane_index_o,
  output logic [j3d_pkg::IDX_W-1:0]         row_index_o,
  output logic [j3d_pkg::IDX_W-1:0]         column_index_o,
  output logic signed [j3d_pkg::DATA_W-1:0] new_value_o,
  output logic                              run_last_o,
  output logic                              grid_done_o
);

  localparam int unsigned IW = j3d_pkg::IDX_W;

  logic out_valid_q, out_valid_d, pend_q, pend_d;
  logic load_first, load_second, move_second;

  logic [IW-1:0] plane_q, row_q, col_q, sec_plane_q;
  logic signed [j3d_pkg::DATA_W-1:0] value_q, sec_value_q;
  logic last_q, done_q, sec_done_q;

  assign ready_o = (!out_valid_q || out_ready_i) && !pend_q;

  always_comb begin
    out_valid_d = out_valid_q;
    pend_d      = pend_q;
    load_first  = 1'b0;
    load_second = 1'b0;
    move_second = 1'b0;
    if (out_valid_q && out_ready_i && pend_q) begin
      move_second = 1'b1;
      pend_d      = 1'b0;
    end else if (ready_o) begin
      if (valid_i && item_i.first) begin
        load_first  = 1'b1;
        out_valid_d = 1'b1;
        pend_d      = item_i.last_plane;
      end else if (valid_i && item_i.last_plane) begin
        load_second = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_first) begin
      // the cell one plane behind the arriving word
      plane_q     <= item_i.plane - IW'(1);
      row_q       <= item_i.row;
      col_q       <= item_i.column;
      value_q     <= value_i;
      last_q      <= !item_i.last_plane;
      done_q      <= 1'b0;
      sec_plane_q <= item_i.plane;
      sec_value_q <= item_i.cur;
      sec_done_q  <= item_i.done;
    end else if (load_second) begin
      plane_q <= item_i.plane;
      row_q   <= item_i.row;
      col_q   <= item_i.column;
      value_q <= item_i.cur;
      last_q  <= 1'b1;
      done_q  <= item_i.done;
    end else if (move_second) begin
      // last plane word passes through unchanged, same row and column
      plane_q <= sec_plane_q;
      value_q <= sec_value_q;
      last_q  <= 1'b1;
      done_q  <= sec_done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plane_index_o  = plane_q;
  assign row_index_o    = row_q;
  assign column_index_o = col_q;
  assign new_value_o    = value_q;
  assign run_last_o     = last_q;
  assign grid_done_o    = done_q;

endmodule
